>>> hdl/salc_pkg.sv
// Package for the set-associative cache policy engine.
// Holds widths, defaults, register indexes and the FSM state type. No dependencies.
package salc_pkg;
    localparam int SETS_DEF     = 256;
    localparam int WAYS_DEF     = 8;
    localparam int TAG_BITS_DEF = 20;
    localparam int CYC_W        = 18;
    localparam int BW_W         = 11;
    localparam int MEM_COST     = 100;
    localparam int MAX_BW       = 1024;
    localparam int ADDR_W       = 3;

    localparam logic [ADDR_W-1:0] REG_SET_BITS = 3'd0;
    localparam logic [ADDR_W-1:0] REG_WAYS     = 3'd1;
    localparam logic [ADDR_W-1:0] REG_BW       = 3'd2;
    localparam logic [ADDR_W-1:0] REG_WALLOC   = 3'd3;
    localparam logic [ADDR_W-1:0] REG_WBACK    = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [3:0]      set_bits;
        logic [3:0]      ways;
        logic [BW_W-1:0] block_words;
        logic            walloc;
        logic            wback;
    } t_cfg;
endpackage

>>> hdl/salc_if.sv
// Valid/ready channel interface with a parameterized payload.
// Depends on nothing; used by the top level and the testbench.
interface salc_if #(parameter int W = 1) (input logic i_clk);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/set_assoc_cache_lru_write_policy.sv
// Top level of the set-associative cache policy engine (LRU, write-back/allocate).
// Depends on salc_pkg, salc_if, salc_regs, salc_set_mem and salc_policy.
//
//  channel  direction  payload
//  i_req    in         func, tag, set_index
//  o_rsp    out        hit, dirty_eviction, cycles
//  apb      in/out     configuration registers 0..4 at 4*i
//
// A request is accepted in ST_IDLE, the set row is read into the row register
// in ST_READ, and in ST_DONE the row is written back and the result is
// registered. The next request is taken only after the result has been taken,
// so a stalled output holds the engine. After reset a clearing pass of the set
// memory keeps i_req off.
module set_assoc_cache_lru_write_policy #(
    parameter int SETS     = salc_pkg::SETS_DEF,
    parameter int WAYS     = salc_pkg::WAYS_DEF,
    parameter int TAG_BITS = salc_pkg::TAG_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    salc_if.sink        i_req,
    salc_if.source      o_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import salc_pkg::*;
    localparam int SI_W  = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int AGE_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int SB_LIM = (SETS > 1) ?
        $clog2(SETS + 1) - ((2 ** $clog2(SETS + 1) > SETS) ? 1 : 0) : 0;

    t_cfg cfg;
    t_state r_state, n_state;
    logic r_store;
    logic [TAG_BITS-1:0] r_tag;
    logic [SI_W-1:0] r_idx;
    logic [CYC_W-1:0] r_fill;
    logic r_ovalid;
    logic [CYC_W+1:0] r_odata;
    logic [WAYS-1:0][TAG_BITS-1:0] m_tags, p_tags;
    logic [WAYS-1:0][AGE_W-1:0] m_ages, p_ages;
    logic [WAYS-1:0] m_dirty, m_valid, p_dirty, p_valid;
    logic p_we, p_hit, p_dev, we;
    logic mem_busy;
    logic [CYC_W-1:0] p_cyc;
    logic [3:0] sbits;
    logic [31:0] mask, idx_full;
    logic [BW_W-1:0] bw;

    salc_regs u_regs (.i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
                      .prdata, .pready, .o_cfg(cfg));

    assign i_req.ready = (r_state == ST_IDLE) && !r_ovalid && !mem_busy;
    assign o_rsp.valid = r_ovalid;
    assign o_rsp.data  = r_odata;

    // The masked index is always below SETS, so it needs no further wrapping.
    always_comb begin
        sbits = (32'(cfg.set_bits) > SB_LIM) ? 4'(SB_LIM) : cfg.set_bits;
        mask = (32'd1 << sbits) - 32'd1;
        idx_full = {24'd0, i_req.data[7:0]} & mask;
        bw = (cfg.block_words == '0) ? BW_W'(1) :
             (cfg.block_words > BW_W'(MAX_BW)) ? BW_W'(MAX_BW) : cfg.block_words;
    end

    always_comb begin
        case (r_state)
            ST_IDLE: n_state = (i_req.valid && i_req.ready) ? ST_READ : ST_IDLE;
            ST_READ: n_state = ST_DONE;
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        we = (r_state == ST_DONE) && p_we;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_DONE) r_ovalid <= 1'b1;
            else if (o_rsp.ready) r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_store <= i_req.data[TAG_BITS+8];
            r_tag   <= i_req.data[TAG_BITS+7:8];
            r_idx   <= SI_W'(idx_full);
        end
        r_fill <= CYC_W'(bw) * CYC_W'(MEM_COST);
        if (r_state == ST_DONE) r_odata <= {p_hit, p_dev, p_cyc};
    end

    salc_set_mem #(.SETS(SETS), .WAYS(WAYS), .TAG_BITS(TAG_BITS)) u_mem (
        .i_clk, .i_rst_n, .i_raddr(r_idx), .o_tags(m_tags), .o_ages(m_ages),
        .o_dirty(m_dirty), .o_valid(m_valid), .i_we(we), .i_waddr(r_idx),
        .i_tags(p_tags), .i_ages(p_ages), .i_dirty(p_dirty), .i_valid(p_valid),
        .o_busy(mem_busy));

    salc_policy #(.WAYS(WAYS), .TAG_BITS(TAG_BITS)) u_pol (
        .i_cfg(cfg), .i_store(r_store), .i_tag(r_tag), .i_tags(m_tags),
        .i_ages(m_ages), .i_dirty(m_dirty), .i_valid(m_valid), .i_fill(r_fill),
        .o_tags(p_tags), .o_ages(p_ages), .o_dirty(p_dirty), .o_valid(p_valid),
        .o_we(p_we), .o_hit(p_hit), .o_dev(p_dev), .o_cycles(p_cyc));
endmodule

>>> hdl/salc_regs.sv
// APB-style configuration register file of the cache policy engine.
// Depends on salc_pkg.
module salc_regs (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [4:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    output salc_pkg::t_cfg           o_cfg
);
    import salc_pkg::*;
    t_cfg r_cfg;
    logic [ADDR_W-1:0] w_idx;
    assign w_idx = paddr[4:2];
    assign pready = 1'b1;
    assign o_cfg = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.set_bits    <= 4'd8;
            r_cfg.ways        <= 4'd8;
            r_cfg.block_words <= BW_W'(4);
            r_cfg.walloc      <= 1'b1;
            r_cfg.wback       <= 1'b1;
        end else if (psel && penable && pwrite) begin
            case (w_idx)
                REG_SET_BITS: r_cfg.set_bits    <= pwdata[3:0];
                REG_WAYS:     r_cfg.ways        <= pwdata[3:0];
                REG_BW:       r_cfg.block_words <= pwdata[BW_W-1:0];
                REG_WALLOC:   r_cfg.walloc      <= pwdata[0];
                REG_WBACK:    r_cfg.wback       <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_SET_BITS: prdata = {28'd0, r_cfg.set_bits};
            REG_WAYS:     prdata = {28'd0, r_cfg.ways};
            REG_BW:       prdata = {21'd0, r_cfg.block_words};
            REG_WALLOC:   prdata = {31'd0, r_cfg.walloc};
            REG_WBACK:    prdata = {31'd0, r_cfg.wback};
            default:      prdata = 32'd0;
        endcase
    end
endmodule

>>> hdl/salc_set_mem.sv
// Set memory: one row per set with tag, age, dirty and valid of every way.
// A clearing pass after reset zeroes every row. Depends on salc_pkg.
module salc_set_mem #(
    parameter int SETS     = salc_pkg::SETS_DEF,
    parameter int WAYS     = salc_pkg::WAYS_DEF,
    parameter int TAG_BITS = salc_pkg::TAG_BITS_DEF,
    parameter int SI_W     = (SETS > 1) ? $clog2(SETS) : 1,
    parameter int AGE_W    = (WAYS > 1) ? $clog2(WAYS) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [SI_W-1:0]               i_raddr,
    output logic [WAYS-1:0][TAG_BITS-1:0] o_tags,
    output logic [WAYS-1:0][AGE_W-1:0]    o_ages,
    output logic [WAYS-1:0]               o_dirty,
    output logic [WAYS-1:0]               o_valid,
    input  logic                          i_we,
    input  logic [SI_W-1:0]               i_waddr,
    input  logic [WAYS-1:0][TAG_BITS-1:0] i_tags,
    input  logic [WAYS-1:0][AGE_W-1:0]    i_ages,
    input  logic [WAYS-1:0]               i_dirty,
    input  logic [WAYS-1:0]               i_valid,
    output logic                          o_busy
);
    localparam int ROW_W = WAYS * (TAG_BITS + AGE_W + 2);
    logic [ROW_W-1:0] r_mem [SETS];
    logic [ROW_W-1:0] r_row;
    logic             r_clearing;
    logic [SI_W-1:0]  r_clr_idx;

    // After reset every row is written to zero, one per cycle, so that all
    // lines start invalid, clean and youngest.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clearing) begin
            if (r_clr_idx == SI_W'(SETS - 1)) r_clearing <= 1'b0;
            r_clr_idx <= r_clr_idx + SI_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) r_mem[r_clr_idx] <= '0;
        else if (i_we) r_mem[i_waddr] <= {i_tags, i_ages, i_dirty, i_valid};
        r_row <= r_mem[i_raddr];
    end

    assign {o_tags, o_ages, o_dirty, o_valid} = r_row;
    assign o_busy = r_clearing;
endmodule

>>> hdl/salc_policy.sv
// Lookup and policy logic: hit search, victim choice, LRU update and cost.
// Pure combinational; depends on salc_pkg.
module salc_policy #(
    parameter int WAYS     = salc_pkg::WAYS_DEF,
    parameter int TAG_BITS = salc_pkg::TAG_BITS_DEF,
    parameter int AGE_W    = (WAYS > 1) ? $clog2(WAYS) : 1
) (
    input  salc_pkg::t_cfg                i_cfg,
    input  logic                          i_store,
    input  logic [TAG_BITS-1:0]           i_tag,
    input  logic [WAYS-1:0][TAG_BITS-1:0] i_tags,
    input  logic [WAYS-1:0][AGE_W-1:0]    i_ages,
    input  logic [WAYS-1:0]               i_dirty,
    input  logic [WAYS-1:0]               i_valid,
    input  logic [salc_pkg::CYC_W-1:0]    i_fill,
    output logic [WAYS-1:0][TAG_BITS-1:0] o_tags,
    output logic [WAYS-1:0][AGE_W-1:0]    o_ages,
    output logic [WAYS-1:0]               o_dirty,
    output logic [WAYS-1:0]               o_valid,
    output logic                          o_we,
    output logic                          o_hit,
    output logic                          o_dev,
    output logic [salc_pkg::CYC_W-1:0]    o_cycles
);
    import salc_pkg::*;
    localparam int WC_W = $clog2(WAYS + 1);
    localparam int OLD_W = AGE_W + 1;
    logic [WC_W-1:0] nways;
    logic wb, hit, fresh, found_inv;
    logic [AGE_W-1:0] hw, vw, sel, best;
    logic [OLD_W-1:0] old;

    always_comb begin
        nways = (i_cfg.ways == 4'd0) ? WC_W'(1) :
                (32'(i_cfg.ways) > WAYS) ? WC_W'(WAYS) : WC_W'(i_cfg.ways);
        wb = i_cfg.walloc && i_cfg.wback;
        hit = 1'b0; hw = '0;
        found_inv = 1'b0; vw = '0; best = '0;
        for (int i = WAYS - 1; i >= 0; i--) begin
            if (32'(i) < 32'(nways) && i_valid[i] && i_tags[i] == i_tag) begin
                hit = 1'b1; hw = AGE_W'(i);
            end
            if (32'(i) < 32'(nways) && !i_valid[i]) begin
                found_inv = 1'b1; vw = AGE_W'(i);
            end
        end
        fresh = found_inv;
        if (!found_inv) begin
            for (int i = 0; i < WAYS; i++) begin
                if (32'(i) < 32'(nways) && (i == 0 || i_ages[i] > best)) begin
                    best = i_ages[i]; vw = AGE_W'(i);
                end
            end
        end
        o_tags = i_tags; o_ages = i_ages; o_dirty = i_dirty; o_valid = i_valid;
        o_hit = hit; o_dev = 1'b0; o_we = 1'b1; o_cycles = '0;
        sel = hit ? hw : vw;
        // A miss counts as a fresh access, so the age of every other valid way below WAYS-1 moves up.
        old = (hit) ? {1'b0, i_ages[hw]} : {OLD_W{1'b1}};
        if (hit) begin
            o_cycles = CYC_W'(1);
            if (i_store) begin
                if (wb) o_dirty[hw] = 1'b1;
                else o_cycles = CYC_W'(1 + MEM_COST);
            end
        end else if (i_store && !i_cfg.walloc) begin
            o_cycles = CYC_W'(MEM_COST);
            o_we = 1'b0;
        end else begin
            o_dev = !fresh && i_dirty[vw];
            o_cycles = i_fill + CYC_W'(1) + (o_dev ? i_fill : '0)
                     + ((i_store && !wb) ? CYC_W'(MEM_COST) : '0);
        end
        if (o_we) begin
            for (int i = 0; i < WAYS; i++) begin
                if (32'(i) < 32'(nways) && AGE_W'(i) != sel && i_valid[i]
                    && {1'b0, i_ages[i]} < old && 32'(i_ages[i]) < WAYS - 1)
                    o_ages[i] = i_ages[i] + AGE_W'(1);
            end
            o_ages[sel] = '0;
            if (!hit) begin
                o_tags[sel]  = i_tag;
                o_valid[sel] = 1'b1;
                o_dirty[sel] = i_store && wb;
            end
        end
    end
endmodule

>>> hdl/salc_checker.sv
// Port-level checker for the cache policy engine, bound to the top level.
// Depends on nothing but the top level that it is bound to.
module salc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [19:0] rsp_data
);
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("response changed while stalled");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while busy");
    a_rsp_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_valid && req_ready |=> ##2 rsp_valid)
        else $error("response missing after request");
    a_hit_cost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid && rsp_data[19] |-> !rsp_data[18] &&
        (rsp_data[17:0] == 18'd1 || rsp_data[17:0] == 18'd101))
        else $error("bad hit cost");
endmodule

bind set_assoc_cache_lru_write_policy salc_checker u_chk (
    .i_clk, .i_rst_n, .req_valid(i_req.valid), .req_ready(i_req.ready),
    .rsp_valid(o_rsp.valid), .rsp_ready(o_rsp.ready), .rsp_data(o_rsp.data));

>>> tb/tb_top.sv
// Testbench for the set-associative cache policy engine (LRU, write-back, write-allocate).
// Depends on salc_pkg, salc_if and the top level set_assoc_cache_lru_write_policy.
// A directed table runs first, then random phases under several register settings.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import salc_pkg::*;

    localparam int NSETS = 256;
    localparam int NWAYS = 8;
    localparam int NLINES = NSETS * NWAYS;

    typedef struct packed {
        logic        func;
        logic [19:0] tag;
        logic [7:0]  set_index;
    } t_access;

    typedef struct packed {
        logic             hit;
        logic             dirty_eviction;
        logic [CYC_W-1:0] cycles;
    } t_outcome;

    typedef struct {
        logic        func;
        logic [19:0] tag;
        logic [7:0]  set_index;
        bit          known;
        t_outcome    want;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    salc_if #(.W($bits(t_access)))  req_if (i_clk);
    salc_if #(.W($bits(t_outcome))) rsp_if (i_clk);

    set_assoc_cache_lru_write_policy u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req_if.sink), .o_rsp(rsp_if.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow of the cache state and registers.
    logic [19:0] sh_tag [NLINES];
    bit          sh_valid [NLINES];
    bit          sh_dirty [NLINES];
    int unsigned sh_age [NLINES];
    int unsigned cf_set_bits, cf_ways, cf_bw, cf_walloc, cf_wback;

    t_outcome pending_outcomes [$];
    int errors = 0;
    int accesses = 0;
    int outcomes_seen = 0;
    int hits_seen = 0;
    int dirty_seen = 0;
    bit hold_off_req = 0;

    task automatic report(string what, int got, int want);
        errors++;
        if (errors <= 30)
            $display("tb: mismatch %s: got %0d expected %0d at %0t",
                     what, got, want, $realtime);
    endtask

    function automatic void promote(int unsigned base, int unsigned nways, int unsigned w,
                                    bit fresh);
        int unsigned old;
        old = fresh ? 32'hFF : sh_age[base + w];
        for (int unsigned i = 0; i < nways; i++) begin
            if (i != w && sh_valid[base + i] && sh_age[base + i] < old &&
                sh_age[base + i] < NWAYS - 1)
                sh_age[base + i]++;
        end
        sh_age[base + w] = 0;
    endfunction

    function automatic t_outcome predict_access(t_access a);
        t_outcome r;
        int unsigned bits, nways, bw, fill, base, idx, w, victim, best, cyc;
        bit alloc, wb, hit, fresh, dev;
        bits = (cf_set_bits > 8) ? 8 : cf_set_bits;
        nways = (cf_ways < 1) ? 1 : (cf_ways > NWAYS) ? NWAYS : cf_ways;
        bw = (cf_bw < 1) ? 1 : (cf_bw > MAX_BW) ? MAX_BW : cf_bw;
        alloc = cf_walloc[0];
        wb = alloc && cf_wback[0];
        fill = bw * MEM_COST;
        idx = a.set_index & ((1 << bits) - 1);
        base = idx * NWAYS;
        hit = 0;
        dev = 0;
        cyc = 0;
        w = 0;
        for (int unsigned i = 0; i < nways; i++) begin
            if (!hit && sh_valid[base + i] && sh_tag[base + i] == a.tag) begin
                hit = 1;
                w = i;
            end
        end
        if (hit) begin
            cyc = 1;
            if (a.func) begin
                if (wb) sh_dirty[base + w] = 1;
                else cyc += MEM_COST;
            end
            promote(base, nways, w, 0);
        end else if (a.func && !alloc) begin
            cyc = MEM_COST;
        end else begin
            fresh = 0;
            victim = 0;
            for (int unsigned i = 0; i < nways; i++) begin
                if (!fresh && !sh_valid[base + i]) begin
                    victim = i;
                    fresh = 1;
                end
            end
            if (!fresh) begin
                best = 0;
                for (int unsigned i = 0; i < nways; i++) begin
                    if (i == 0 || sh_age[base + i] > best) begin
                        best = sh_age[base + i];
                        victim = i;
                    end
                end
                if (sh_dirty[base + victim]) begin
                    dev = 1;
                    cyc += fill;
                end
                sh_age[base + victim] = 32'hFF;
            end
            cyc += fill + 1;
            if (a.func && !wb) cyc += MEM_COST;
            promote(base, nways, victim, 1);
            sh_tag[base + victim] = a.tag;
            sh_valid[base + victim] = 1;
            sh_dirty[base + victim] = a.func && wb;
        end
        r.hit = hit;
        r.dirty_eviction = dev;
        r.cycles = cyc[CYC_W-1:0];
        return r;
    endfunction

    // Short gaps mostly, long ones now and then.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic reg_write(logic [ADDR_W-1:0] idx, int unsigned value);
        @(negedge i_clk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = {idx, 2'b00};
        pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic apply_settings(int unsigned sb, int unsigned wy, int unsigned bw,
                                  int unsigned wa, int unsigned wbk);
        wait (pending_outcomes.size() == 0);
        repeat (8) @(posedge i_clk);
        reg_write(REG_SET_BITS, sb);
        reg_write(REG_WAYS, wy);
        reg_write(REG_BW, bw);
        reg_write(REG_WALLOC, wa);
        reg_write(REG_WBACK, wbk);
        cf_set_bits = sb & 4'hF;
        cf_ways = wy & 4'hF;
        cf_bw = bw & 11'h7FF;
        cf_walloc = wa & 1;
        cf_wback = wbk & 1;
    endtask

    // Offers one access and returns at the edge where it is taken, with valid still high.
    task automatic offer_access(t_access a, output t_outcome got_pred);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            req_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.valid = 1'b1;
        req_if.data = a;
        do @(posedge i_clk); while (!req_if.ready);
        got_pred = predict_access(a);
        pending_outcomes.insert(pending_outcomes.size(), got_pred);
        accesses++;
    endtask

    task automatic pause_sender();
        @(negedge i_clk);
        req_if.valid = 1'b0;
        wait (pending_outcomes.size() == 0);
    endtask

    // Receiver: random ready, plus one long hold-off on request.
    initial begin
        int gap;
        int held;
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                rsp_if.ready = 1'b0;
                for (held = 0; held < 300; held++) @(negedge i_clk);
                hold_off_req = 0;
            end
            gap = pick_gap();
            rsp_if.ready = (gap == 0);
            if (gap > 1) begin
                repeat (gap - 1) @(negedge i_clk);
                rsp_if.ready = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_outcome got, want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            got = rsp_if.data;
            outcomes_seen++;
            if (got.hit) hits_seen++;
            if (got.dirty_eviction) dirty_seen++;
            if (pending_outcomes.size() == 0) begin
                report("unexpected result", got.cycles, -1);
            end else begin
                want = pending_outcomes.pop_front();
                if (got.hit !== want.hit) report("hit", got.hit, want.hit);
                if (got.dirty_eviction !== want.dirty_eviction)
                    report("dirty_eviction", got.dirty_eviction, want.dirty_eviction);
                if (got.cycles !== want.cycles) report("cycles", got.cycles, want.cycles);
            end
        end
    end

    initial begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

    initial begin
        t_row rows [$];
        t_row row;
        t_access a;
        t_outcome p;
        logic [19:0] pool [16];
        int unsigned set_pool [4];
        int phase;
        int n;

        req_if.valid = 1'b0;
        req_if.data = '0;
        for (int i = 0; i < NLINES; i++) begin
            sh_valid[i] = 0;
            sh_dirty[i] = 0;
            sh_age[i] = 0;
            sh_tag[i] = '0;
        end
        cf_set_bits = 8;
        cf_ways = 8;
        cf_bw = 4;
        cf_walloc = 1;
        cf_wback = 1;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        repeat (4) @(posedge i_clk);

        // Directed rows under the reset settings: cold misses, hits, a full set, dirty victims.
        row = '{0, 20'h00000, 8'h00, 1, '{0, 0, 401}};
        rows.insert(rows.size(), row);
        row = '{1, 20'h00000, 8'h00, 1, '{1, 0, 1}};
        rows.insert(rows.size(), row);
        row = '{0, 20'hFFFFF, 8'hFF, 1, '{0, 0, 401}};
        rows.insert(rows.size(), row);
        row = '{1, 20'hFFFFF, 8'hFF, 1, '{1, 0, 1}};
        rows.insert(rows.size(), row);
        row = '{1, 20'h12345, 8'h00, 1, '{0, 0, 401}};
        rows.insert(rows.size(), row);
        for (int t = 1; t <= 6; t++) begin
            row = '{0, t[19:0], 8'h00, 1, '{0, 0, 401}};
            rows.insert(rows.size(), row);
        end
        row = '{0, 20'h00007, 8'h00, 1, '{0, 1, 801}};
        rows.insert(rows.size(), row);
        row = '{0, 20'h00000, 8'h00, 1, '{0, 1, 801}};
        rows.insert(rows.size(), row);
        row = '{0, 20'h00000, 8'h00, 1, '{1, 0, 1}};
        rows.insert(rows.size(), row);
        row = '{1, 20'h00003, 8'h00, 0, '{0, 0, 0}};
        rows.insert(rows.size(), row);
        row = '{0, 20'hABCDE, 8'h80, 0, '{0, 0, 0}};
        rows.insert(rows.size(), row);
        row = '{1, 20'h55555, 8'h7F, 0, '{0, 0, 0}};
        rows.insert(rows.size(), row);
        foreach (rows[i]) begin
            row = rows[i];
            a.func = row.func;
            a.tag = row.tag;
            a.set_index = row.set_index;
            offer_access(a, p);
            if (row.known && p !== row.want)
                report("directed row cycles", p.cycles, row.want.cycles);
        end
        pause_sender();

        for (phase = 0; phase < 9; phase++) begin
            case (phase)
                0: apply_settings(0, 1, 1, 1, 1);
                1: apply_settings(15, 15, 2047, 0, 1);
                2: apply_settings(2, 2, 1024, 1, 0);
                3: apply_settings(3, 0, 0, 0, 0);
                4: apply_settings(8, 8, 4, 1, 1);
                5: apply_settings(1, 4, 7, 1, 1);
                6: apply_settings(4, 8, 1, 1, 0);
                default: apply_settings($urandom_range(0, 15), $urandom_range(0, 15),
                                        $urandom_range(1, 16), $urandom_range(0, 1),
                                        $urandom_range(0, 1));
            endcase
            // A small working set per phase so that hits, fills and evictions all occur.
            foreach (pool[i]) pool[i] = $urandom_range(0, 20'hFFFFF);
            foreach (set_pool[i]) set_pool[i] = $urandom_range(0, 255);
            n = (phase == 1 || phase == 2) ? 60 : 230;
            for (int k = 0; k < n; k++) begin
                a.func = $urandom_range(0, 1);
                if ($urandom_range(0, 9) < 8) begin
                    a.tag = pool[$urandom_range(0, 15)];
                    a.set_index = set_pool[$urandom_range(0, 3)];
                end else begin
                    a.tag = $urandom_range(0, 20'hFFFFF);
                    a.set_index = $urandom_range(0, 255);
                end
                if (phase == 4 && k == 20) hold_off_req = 1;
                if (phase == 5 && k == 100) pause_sender();
                offer_access(a, p);
            end
            pause_sender();
        end

        wait (pending_outcomes.size() == 0);
        repeat (20) @(posedge i_clk);
        $display("tb: %0d accesses over 10 register settings, %0d results,",
                 accesses, outcomes_seen);
        $display("tb: %0d hits and %0d dirty evictions seen", hits_seen, dirty_seen);
        if (errors == 0 && pending_outcomes.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
